// ----- design/dmar_pkg.sv -----
// Shared types, constants and codes for the DMA descriptor ring manager.
package dmar_pkg;

  localparam int CHANNEL_COUNT  = 4;
  localparam int MAX_RING_ORDER = 8;

  localparam int CH_AW       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int PTR_W       = MAX_RING_ORDER;
  localparam int SIZE_W      = PTR_W + 1;
  localparam int ORD_EFF_W   = $clog2(MAX_RING_ORDER + 1);
  localparam int ORDER_W     = 4;
  localparam int LEN_W       = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'd1;

  localparam logic [ORDER_W-1:0] RING_ORDER_RST = 4'd8;
  localparam logic [LEN_W-1:0]   MAX_LEN_RST    = 32'd1048576;

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_RETIRE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic        action;
    logic [1:0]  channel;
    logic [63:0] buffer_address;
    logic [31:0] transfer_length;
    logic        done_flag;
    logic        error_flag;
    logic [31:0] bytes_moved;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  doorbell_head;
    logic [7:0]  slot_index;
    logic [63:0] desc_address;
    logic [31:0] desc_length;
    logic        desc_valid;
    logic [7:0]  free_slots;
    logic [31:0] completed_total;
    logic [63:0] bytes_total;
    logic [31:0] error_total;
    logic        completion_signal;
  } out_item_t;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [31:0]      completed;
    logic [63:0]      bytes;
    logic [31:0]      errors;
  } ring_entry_t;

  localparam int ENTRY_W = $bits(ring_entry_t);

endpackage

// ----- design/dmar_xfer_if.sv -----
// Valid/ready channel interfaces for submit/retire requests and results.
interface dmar_in_if import dmar_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dmar_out_if import dmar_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/dmar_state_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dmar_state_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/dmar_step_unit.sv -----
// Read-modify-write datapath: ring pointer checks and counter updates for one request.
module dmar_step_unit import dmar_pkg::*; (
  input  in_item_t          item,
  input  ring_entry_t       entry,
  input  logic [ORDER_W-1:0] ring_order,
  input  logic [LEN_W-1:0]  max_len,
  output ring_entry_t       entry_nxt,
  output logic              wr_en,
  output out_item_t         result
);

  function automatic logic [SIZE_W-1:0] free_cnt(input logic [SIZE_W-1:0] size,
                                                 input logic [PTR_W-1:0]  h,
                                                 input logic [PTR_W-1:0]  t);
    logic [SIZE_W-1:0] r;
    if (h >= t) begin
      r = size - SIZE_W'(h) + SIZE_W'(t) - SIZE_W'(1);
    end else begin
      r = SIZE_W'(t) - SIZE_W'(h) - SIZE_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    logic [ORD_EFF_W-1:0] ord_eff;
    logic [SIZE_W-1:0]    size;
    logic [PTR_W-1:0]     mask;
    logic [PTR_W-1:0]     h;
    logic [PTR_W-1:0]     t;
    logic [SIZE_W-1:0]    free_pre;
    logic [SIZE_W-1:0]    free_post;

    result    = '0;
    entry_nxt = entry;
    wr_en     = 1'b0;
    free_post = '0;

    ord_eff = ORD_EFF_W'(ring_order);
    if (ring_order == '0) begin
      ord_eff = ORD_EFF_W'(1);
    end
    if (32'(ring_order) > MAX_RING_ORDER) begin
      ord_eff = ORD_EFF_W'(MAX_RING_ORDER);
    end
    size     = SIZE_W'(1) << ord_eff;
    mask     = PTR_W'(size - SIZE_W'(1));
    h        = entry.head & mask;
    t        = entry.tail & mask;
    free_pre = free_cnt(size, h, t);

    if (32'(item.channel) >= CHANNEL_COUNT) begin
      result.status = ST_INVALID;
    end else begin
      wr_en = 1'b1;
      if (item.action == ACT_SUBMIT) begin
        if (item.transfer_length > max_len) begin
          result.status = ST_INVALID;
        end else if (free_pre == '0) begin
          result.status = ST_FULL;
        end else begin
          result.slot_index   = 8'(h);
          result.desc_address = item.buffer_address;
          result.desc_length  = item.transfer_length;
          result.desc_valid   = 1'b1;
          h = (h + PTR_W'(1)) & mask;
        end
      end else begin
        if (h == t) begin
          result.status = ST_EMPTY;
        end else begin
          result.slot_index = 8'(t);
          if (item.done_flag) begin
            entry_nxt.completed = entry.completed + 32'd1;
            entry_nxt.bytes     = entry.bytes + 64'(item.bytes_moved);
            if (item.error_flag) begin
              entry_nxt.errors = entry.errors + 32'd1;
            end
            result.completion_signal = 1'b1;
          end
          t = (t + PTR_W'(1)) & mask;
        end
      end
      free_post              = free_cnt(size, h, t);
      entry_nxt.head         = h;
      entry_nxt.tail         = t;
      result.doorbell_head   = 8'(h);
      result.free_slots      = 8'(free_post);
      result.completed_total = entry_nxt.completed;
      result.bytes_total     = entry_nxt.bytes;
      result.error_total     = entry_nxt.errors;
    end
  end

endmodule

// ----- design/dma_descriptor_ring_manager_top.sv -----
// Top level of the DMA descriptor ring manager: control, state RAM and result register.
// A request reads its state RAM entry when accepted; the execute state writes it back and
// registers the result, stalling on a full output. New requests are taken only when idle.
// Reset: synchronous, active low; per-channel valid bits make every ring read as zero
// pointers and counters until first written, so there is no clearing pass.
// Registers reset to ring_order 8 and max_transfer_length 1048576.
module dma_descriptor_ring_manager_top import dmar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dmar_in_if.sink               in_xfer,
  dmar_out_if.source            out_xfer,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           item_r;
  logic [ORDER_W-1:0] ring_order_r;
  logic [LEN_W-1:0]   max_len_r;
  logic               entry_vld_r [CHANNEL_COUNT];
  logic               rd_vld_r;
  out_item_t          out_r;
  logic               out_vld_r;

  logic               in_acc;
  logic               out_free;
  logic               finish;
  logic [CH_AW-1:0]   rd_addr;
  logic [CH_AW-1:0]   wr_addr;
  logic [ENTRY_W-1:0] ram_q;
  ring_entry_t        entry_cur;
  ring_entry_t        entry_nxt;
  logic               step_wr;
  logic               ram_we;
  out_item_t          step_res;

  assign in_xfer.ready    = (state_r == S_IDLE);
  assign in_acc           = in_xfer.valid && in_xfer.ready;
  assign out_free         = !out_vld_r || out_xfer.ready;
  assign finish           = (state_r == S_EXEC) && out_free;
  assign rd_addr          = CH_AW'(in_xfer.payload.channel);
  assign wr_addr          = CH_AW'(item_r.channel);
  assign ram_we           = finish && step_wr;
  assign entry_cur        = rd_vld_r ? ring_entry_t'(ram_q) : '0;
  assign out_xfer.valid   = out_vld_r;
  assign out_xfer.payload = out_r;

  dmar_state_ram #(
    .DEPTH (CHANNEL_COUNT),
    .WIDTH (ENTRY_W),
    .AW    (CH_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (entry_nxt),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  dmar_step_unit u_step (
    .item       (item_r),
    .entry      (entry_cur),
    .ring_order (ring_order_r),
    .max_len    (max_len_r),
    .entry_nxt  (entry_nxt),
    .wr_en      (step_wr),
    .result     (step_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ring_order_r <= RING_ORDER_RST;
      max_len_r    <= MAX_LEN_RST;
      out_vld_r    <= 1'b0;
      rd_vld_r     <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        entry_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RING_ORDER: ring_order_r <= cfg_wdata[ORDER_W-1:0];
          CFG_MAX_LEN:    max_len_r    <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        rd_vld_r <= entry_vld_r[rd_addr];
      end
      if (ram_we) begin
        entry_vld_r[wr_addr] <= 1'b1;
      end
      if (finish) begin
        out_vld_r <= 1'b1;
      end else if (out_xfer.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_xfer.payload;
    end
    if (finish) begin
      out_r <= step_res;
    end
  end

  a_wr_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_EXEC)
    else $error("state RAM written outside execute state");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == S_EXEC)
    else $error("result appeared without an executed request");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC && !in_xfer.ready)
    else $error("accepted request did not enter execute state");

  a_desc_xor_completion: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.desc_valid && out_r.completion_signal))
    else $error("result flags both a new descriptor and a completion");

endmodule

// ----- test/dma_descriptor_ring_manager_top_test.sv -----
// Testbench for the DMA descriptor ring manager: directed and random submit/retire traffic.
`timescale 1ns / 1ps

module dma_descriptor_ring_manager_top_test;
  import dmar_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dmar_in_if  in_ch ();
  dmar_out_if out_ch ();

  dma_descriptor_ring_manager_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_xfer   (in_ch),
    .out_xfer  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Ring state and register shadow
  logic [ORDER_W-1:0] ring_order_cfg = RING_ORDER_RST;
  logic [LEN_W-1:0]   max_len_cfg    = MAX_LEN_RST;
  logic [7:0]  ring_head   [CHANNEL_COUNT] = '{default: '0};
  logic [7:0]  ring_tail   [CHANNEL_COUNT] = '{default: '0};
  logic [31:0] done_count  [CHANNEL_COUNT] = '{default: '0};
  logic [63:0] byte_sum    [CHANNEL_COUNT] = '{default: '0};
  logic [31:0] fault_count [CHANNEL_COUNT] = '{default: '0};

  in_item_t  request_queue [$];
  out_item_t due_results [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  function automatic int ring_free(input int size, input int h, input int t);
    if (h >= t) return size - h + t - 1;
    return t - h - 1;
  endfunction

  function automatic out_item_t advance_ring(input in_item_t req);
    out_item_t res;
    int ord, size, mask, h, t, ch;
    res = '0;
    res.status = ST_OK;
    ch = req.channel;
    ord = ring_order_cfg;
    if (ord < 1) ord = 1;
    if (ord > MAX_RING_ORDER) ord = MAX_RING_ORDER;
    size = 1 << ord;
    mask = size - 1;
    h = ring_head[ch] & mask;
    t = ring_tail[ch] & mask;
    if (req.action == ACT_SUBMIT) begin
      if (req.transfer_length > max_len_cfg) begin
        res.status = ST_INVALID;
      end else if (ring_free(size, h, t) == 0) begin
        res.status = ST_FULL;
      end else begin
        res.slot_index = 8'(h);
        res.desc_address = req.buffer_address;
        res.desc_length = req.transfer_length;
        res.desc_valid = 1'b1;
        h = (h + 1) & mask;
      end
    end else begin
      if (h == t) begin
        res.status = ST_EMPTY;
      end else begin
        res.slot_index = 8'(t);
        if (req.done_flag) begin
          done_count[ch] = done_count[ch] + 1;
          byte_sum[ch] = byte_sum[ch] + 64'(req.bytes_moved);
          if (req.error_flag) fault_count[ch] = fault_count[ch] + 1;
          res.completion_signal = 1'b1;
        end
        t = (t + 1) & mask;
      end
    end
    ring_head[ch] = 8'(h);
    ring_tail[ch] = 8'(t);
    res.doorbell_head = 8'(h);
    res.free_slots = 8'(ring_free(size, h, t));
    res.completed_total = done_count[ch];
    res.bytes_total = byte_sum[ch];
    res.error_total = fault_count[ch];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      $error("result transfer with no request outstanding");
      fail_count++;
    end else begin
      want = due_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("doorbell_head", want.doorbell_head, got.doorbell_head);
      check_field("slot_index", want.slot_index, got.slot_index);
      check_field("desc_address", want.desc_address, got.desc_address);
      check_field("desc_length", want.desc_length, got.desc_length);
      check_field("desc_valid", want.desc_valid, got.desc_valid);
      check_field("free_slots", want.free_slots, got.free_slots);
      check_field("completed_total", want.completed_total, got.completed_total);
      check_field("bytes_total", want.bytes_total, got.bytes_total);
      check_field("error_total", want.error_total, got.error_total);
      check_field("completion_signal", want.completion_signal, got.completion_signal);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(advance_ring(in_ch.payload));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.payload <= request_queue.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.payload);
      end
      out_ch.ready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t make_item(input logic act, input logic [1:0] ch,
                                         input logic [63:0] addr, input logic [31:0] len,
                                         input logic done, input logic err,
                                         input logic [31:0] moved);
    in_item_t it;
    it.action = act;
    it.channel = ch;
    it.buffer_address = addr;
    it.transfer_length = len;
    it.done_flag = done;
    it.error_flag = err;
    it.bytes_moved = moved;
    return it;
  endfunction

  function automatic in_item_t rand_item(input int submit_pct, input int chan);
    in_item_t it;
    int r;
    it.action = ($urandom_range(99) < submit_pct) ? ACT_SUBMIT : ACT_RETIRE;
    it.channel = (chan < 0) ? 2'($urandom_range(3)) : 2'(chan);
    r = $urandom_range(99);
    if (r < 5) it.buffer_address = '0;
    else if (r < 10) it.buffer_address = '1;
    else it.buffer_address = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 8) it.transfer_length = $urandom;
    else if (r < 12) it.transfer_length = max_len_cfg;
    else if (r < 16) it.transfer_length = max_len_cfg + 1;
    else if (r < 20) it.transfer_length = '0;
    else it.transfer_length = $urandom_range(max_len_cfg);
    r = $urandom_range(99);
    if (r < 5) it.bytes_moved = '0;
    else if (r < 10) it.bytes_moved = '1;
    else it.bytes_moved = $urandom;
    it.done_flag = ($urandom_range(99) < 80);
    it.error_flag = ($urandom_range(99) < 25);
    return it;
  endfunction

  task automatic wait_idle();
    while (request_queue.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_RING_ORDER) ring_order_cfg = data[ORDER_W-1:0];
    else max_len_cfg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] order, input logic [CFG_DATA_W-1:0] max_len,
                           input int sidle, input int rstall, input int count);
    int bias;
    wait_idle();
    write_reg(CFG_RING_ORDER, order);
    write_reg(CFG_MAX_LEN, max_len);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < count; i++) begin
      bias = ((i / 24) % 2 == 0) ? 70 : 30;
      request_queue.push_back(rand_item(bias, -1));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: default registers
    request_queue.push_back(make_item(ACT_RETIRE, 2'd3, '0, '0, 1'b1, 1'b1, '1));
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd0, '0, '0, 1'b0, 1'b0, '0));
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd1, '1, MAX_LEN_RST, 1'b1, 1'b1, '1));
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd2, {$urandom, $urandom},
                                      MAX_LEN_RST + 1, 1'b0, 1'b0, '0));
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd3, '1, '1, 1'b0, 1'b0, '0));
    request_queue.push_back(make_item(ACT_RETIRE, 2'd0, '0, '0, 1'b1, 1'b1, '1));
    request_queue.push_back(make_item(ACT_RETIRE, 2'd1, '0, '0, 1'b0, 1'b1, '1));
    request_queue.push_back(make_item(ACT_RETIRE, 2'd1, '0, '0, 1'b1, 1'b0, $urandom));
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd2, {$urandom, $urandom}, 32'd100,
                                      1'b0, 1'b0, '0));
    request_queue.push_back(make_item(ACT_RETIRE, 2'd2, '0, '0, 1'b0, 1'b0, $urandom));

    // Smallest ring, zero length limit
    wait_idle();
    write_reg(CFG_RING_ORDER, 32'd1);
    write_reg(CFG_MAX_LEN, 32'd0);
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd0, '1, '0, 1'b0, 1'b0, '0));
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd0, '0, '0, 1'b0, 1'b0, '0));
    request_queue.push_back(make_item(ACT_SUBMIT, 2'd1, '0, 32'd1, 1'b0, 1'b0, '0));
    request_queue.push_back(make_item(ACT_RETIRE, 2'd0, '0, '0, 1'b1, 1'b0, '0));
    request_queue.push_back(make_item(ACT_RETIRE, 2'd0, '0, '0, 1'b1, 1'b1, '1));

    // Ring shrunk while slots are in use
    wait_idle();
    write_reg(CFG_RING_ORDER, 32'd3);
    write_reg(CFG_MAX_LEN, '1);
    for (int i = 0; i < 5; i++)
      request_queue.push_back(rand_item(100, 3));
    wait_idle();
    write_reg(CFG_RING_ORDER, 32'd2);
    for (int i = 0; i < 4; i++)
      request_queue.push_back(rand_item(i % 2 == 0 ? 0 : 100, 3));

    // Random traffic
    run_phase(32'd2, '1, 0, 0, 250);
    run_phase(32'd3, 32'd4096, 68, 0, 250);
    run_phase(32'd1, 32'd0, 0, 68, 200);
    run_phase(32'd0, 32'd65535, 10, 10, 200);

    // Fill one ring while the result side holds off, then drain it
    run_phase(32'd15, MAX_LEN_RST, 0, 0, 0);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 260; i++)
      request_queue.push_back(rand_item(100, 0));
    wait_idle();
    for (int i = 0; i < 260; i++)
      request_queue.push_back(rand_item(0, 0));

    run_phase(32'd4, $urandom, 68, 68, 100);
    run_phase(32'd5, $urandom, 10, 10, 130);
    run_phase(32'd8, '1, 0, 68, 130);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
